// ===== rtl/bha_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none

package bha_pkg;

  // Region and header geometry defaults.
  localparam int BHA_HEAP_BYTES   = 65536;
  localparam int BHA_HEADER_BYTES = 12;

  // Field widths fixed by the interface.
  localparam int ADDR_W   = 32;
  localparam int ACT_W    = 2;
  localparam int STS_W    = 3;
  localparam int KIND_W   = 2;
  localparam int LEN_W    = 17;
  localparam int TKIND_W  = 2;

  // Rounding of request sizes to 8 bytes, and the zero-fill request bit.
  localparam int ALIGN_MASK    = 7;
  localparam int ZERO_FLAG_BIT = 3;

  // Request actions.
  localparam logic [ACT_W-1:0] ACT_ALLOC   = 2'd0;
  localparam logic [ACT_W-1:0] ACT_FREE    = 2'd1;
  localparam logic [ACT_W-1:0] ACT_REALLOC = 2'd2;
  localparam logic [ACT_W-1:0] ACT_SIZE    = 2'd3;

  // Result status codes.
  localparam logic [STS_W-1:0] STS_OK         = 3'd0;
  localparam logic [STS_W-1:0] STS_NO_SPACE   = 3'd1;
  localparam logic [STS_W-1:0] STS_OUT_RANGE  = 3'd2;
  localparam logic [STS_W-1:0] STS_DOUBLE_FREE = 3'd3;
  localparam logic [STS_W-1:0] STS_BAD_HEADER = 3'd4;
  localparam logic [STS_W-1:0] STS_NULL_PTR   = 3'd5;

  // Move command kinds.
  localparam logic [KIND_W-1:0] MOVE_NONE = 2'd0;
  localparam logic [KIND_W-1:0] MOVE_ZERO = 2'd1;
  localparam logic [KIND_W-1:0] MOVE_COPY = 2'd2;

  // Header tag kinds.
  localparam logic [TKIND_W-1:0] TAG_NONE  = 2'd0;
  localparam logic [TKIND_W-1:0] TAG_LIVE  = 2'd1;
  localparam logic [TKIND_W-1:0] TAG_FREED = 2'd2;

  // Controller to datapath.
  typedef struct packed {
    logic load;    // capture the accepted request
    logic clear;   // write the next entry of the clearing pass
    logic commit;  // apply the decided action and load the result register
    logic wr_old;  // write the freed header of a reallocated block
  } bha_cmd_t;

  // Datapath to controller.
  typedef struct packed {
    logic clear_last;   // clearing pass is at its last entry
    logic out_free;     // result register can take a new transaction
    logic need_second;  // action needs a second tag write
  } bha_sts_t;

endpackage

`default_nettype wire

// ===== rtl/bha_in_if.sv =====
`timescale 1ns / 1ps
`default_nettype none

interface bha_in_if;
  import bha_pkg::*;

  logic              valid;
  logic              ready;
  logic [ACT_W-1:0]  action;
  logic [ADDR_W-1:0] request_flags;
  logic [ADDR_W-1:0] block_pointer;
  logic [ADDR_W-1:0] request_size;

  modport source (output valid, action, request_flags, block_pointer, request_size,
                  input ready);
  modport sink   (input valid, action, request_flags, block_pointer, request_size,
                  output ready);
endinterface

`default_nettype wire

// ===== rtl/bha_out_if.sv =====
`timescale 1ns / 1ps
`default_nettype none

interface bha_out_if;
  import bha_pkg::*;

  logic              valid;
  logic              ready;
  logic [ADDR_W-1:0] result_value;
  logic [STS_W-1:0]  status;
  logic [KIND_W-1:0] move_kind;
  logic [ADDR_W-1:0] move_source;
  logic [ADDR_W-1:0] move_destination;
  logic [LEN_W-1:0]  move_length;
  logic [ADDR_W-1:0] bytes_allocated_total;
  logic [ADDR_W-1:0] bytes_freed_total;

  modport source (output valid, result_value, status, move_kind, move_source,
                  move_destination, move_length, bytes_allocated_total,
                  bytes_freed_total,
                  input ready);
  modport sink   (input valid, result_value, status, move_kind, move_source,
                  move_destination, move_length, bytes_allocated_total,
                  bytes_freed_total,
                  output ready);
endinterface

`default_nettype wire

// ===== rtl/bha_cfg_if.sv =====
`timescale 1ns / 1ps
`default_nettype none

interface bha_cfg_if;
  import bha_pkg::*;

  logic              valid;
  logic              ready;
  logic [ADDR_W-1:0] data;

  modport source (output valid, data, input ready);
  modport sink   (input valid, data, output ready);
endinterface

`default_nettype wire

// ===== rtl/bha_ctrl.sv =====
`timescale 1ns / 1ps
`default_nettype none

module bha_ctrl
  import bha_pkg::*;
(
  input  wire logic     clk,
  input  wire logic     rst_n,
  input  wire logic     in_valid,
  output logic          in_ready,
  input  wire bha_sts_t sts,
  output bha_cmd_t      cmd
);

  localparam logic [2:0] S_CLEAR = 3'd0;
  localparam logic [2:0] S_IDLE  = 3'd1;
  localparam logic [2:0] S_READ  = 3'd2;
  localparam logic [2:0] S_EXEC  = 3'd3;
  localparam logic [2:0] S_FREE  = 3'd4;

  logic [2:0] state_r;
  logic [2:0] state_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_CLEAR;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_comb begin
    state_nxt  = state_r;
    in_ready   = 1'b0;
    cmd        = '0;
    unique case (state_r)
      S_CLEAR: begin
        cmd.clear = 1'b1;
        if (sts.clear_last) begin
          state_nxt = S_IDLE;
        end
      end
      S_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          cmd.load  = 1'b1;
          state_nxt = S_READ;
        end
      end
      S_READ: begin
        // The tag read issued here returns at the next edge.
        state_nxt = S_EXEC;
      end
      S_EXEC: begin
        if (sts.out_free) begin
          cmd.commit = 1'b1;
          state_nxt  = sts.need_second ? S_FREE : S_IDLE;
        end
      end
      S_FREE: begin
        cmd.wr_old = 1'b1;
        state_nxt  = S_IDLE;
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

endmodule

`default_nettype wire

// ===== rtl/bha_datapath.sv =====
`timescale 1ns / 1ps
`default_nettype none

module bha_datapath
  import bha_pkg::*;
#(
  parameter int HEAP_BYTES   = BHA_HEAP_BYTES,
  parameter int HEADER_BYTES = BHA_HEADER_BYTES
) (
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire logic              cfg_we,
  input  wire logic [ADDR_W-1:0] cfg_data,
  input  wire logic [ACT_W-1:0]  in_action,
  input  wire logic [ADDR_W-1:0] in_request_flags,
  input  wire logic [ADDR_W-1:0] in_block_pointer,
  input  wire logic [ADDR_W-1:0] in_request_size,
  input  wire bha_cmd_t          cmd,
  output bha_sts_t               sts,
  bha_out_if.source              out_ch
);

  localparam int DEPTH = (HEAP_BYTES + 3) / 4;
  localparam int IDXW  = $clog2(DEPTH);
  localparam int OFFW  = $clog2(HEAP_BYTES + 1);
  localparam int TAGW  = TKIND_W + OFFW;

  // Header tag store: one entry per 4-byte word of the region.
  logic [TAGW-1:0] tag_mem [DEPTH];
  logic [TAGW-1:0] rd_data_r;
  logic [IDXW-1:0] rd_addr;
  logic            we;
  logic [IDXW-1:0] waddr;
  logic [TAGW-1:0] wdata;

  logic [IDXW-1:0]   clr_cnt_r;
  logic [ADDR_W-1:0] base_r;
  logic [OFFW-1:0]   nfo_r;
  logic [OFFW-1:0]   nfo_nxt;
  logic [ADDR_W-1:0] alloc_sum_r;
  logic [ADDR_W-1:0] alloc_sum_nxt;
  logic [ADDR_W-1:0] freed_sum_r;
  logic [ADDR_W-1:0] freed_sum_nxt;

  logic [ACT_W-1:0]  act_r;
  logic [ADDR_W-1:0] flags_r;
  logic [ADDR_W-1:0] ptr_r;
  logic [ADDR_W-1:0] size_r;

  logic              out_valid_r;
  logic [ADDR_W-1:0] res_r;
  logic [STS_W-1:0]  status_r;
  logic [KIND_W-1:0] kind_r;
  logic [ADDR_W-1:0] src_r;
  logic [ADDR_W-1:0] dst_r;
  logic [LEN_W-1:0]  len_r;

  // Header lookup.
  logic [ADDR_W-1:0]  off;
  logic [ADDR_W-1:0]  hoff;
  logic               in_rng;
  logic [TKIND_W-1:0] t_kind;
  logic [OFFW-1:0]    t_size;
  logic [STS_W-1:0]   hdr_sts;

  // Bump allocation.
  logic [ADDR_W:0]   aligned;
  logic [ADDR_W+1:0] total;
  logic              fit;
  logic [ADDR_W-1:0] new_addr;
  logic [OFFW-1:0]   asize;
  logic [IDXW-1:0]   nfo_idx;
  logic [ADDR_W-1:0] copy_len;

  // Decision.
  logic              do_alloc;
  logic              do_release;
  logic [ADDR_W-1:0] res;
  logic [STS_W-1:0]  status;
  logic [KIND_W-1:0] kind;
  logic [ADDR_W-1:0] src;
  logic [ADDR_W-1:0] dst;
  logic [LEN_W-1:0]  len;

  assign off     = ptr_r - base_r;
  assign in_rng  = (off >= ADDR_W'(HEADER_BYTES)) && (off < ADDR_W'(HEAP_BYTES));
  assign hoff    = off - ADDR_W'(HEADER_BYTES);
  assign rd_addr = hoff[IDXW+1:2];
  assign t_kind  = rd_data_r[TAGW-1 -: TKIND_W];
  assign t_size  = rd_data_r[OFFW-1:0];

  always_comb begin
    if (!in_rng) begin
      hdr_sts = STS_OUT_RANGE;
    end else if (hoff[1:0] != 2'b00) begin
      hdr_sts = STS_BAD_HEADER;
    end else if (t_kind == TAG_LIVE) begin
      hdr_sts = STS_OK;
    end else if (t_kind == TAG_FREED) begin
      hdr_sts = STS_DOUBLE_FREE;
    end else begin
      hdr_sts = STS_BAD_HEADER;
    end
  end

  assign aligned  = ({1'b0, size_r} + (ADDR_W+1)'(ALIGN_MASK)) & ~(ADDR_W+1)'(ALIGN_MASK);
  assign total    = {1'b0, aligned} + (ADDR_W+2)'(HEADER_BYTES);
  assign fit      = ((ADDR_W+2)'(nfo_r) + total) <= (ADDR_W+2)'(HEAP_BYTES);
  assign new_addr = base_r + ADDR_W'(nfo_r) + ADDR_W'(HEADER_BYTES);
  assign asize    = aligned[OFFW-1:0];
  assign nfo_idx  = nfo_r[IDXW+1:2];
  assign copy_len = (size_r < ADDR_W'(t_size)) ? size_r : ADDR_W'(t_size);

  always_comb begin
    logic ptr_null;
    logic size_zero;
    logic [ADDR_W-1:0] asize_w;
    ptr_null   = (ptr_r == '0);
    size_zero  = (size_r == '0);
    asize_w    = ADDR_W'(asize);
    do_alloc   = 1'b0;
    do_release = 1'b0;
    res        = '0;
    status     = STS_OK;
    kind       = MOVE_NONE;
    src        = '0;
    dst        = '0;
    len        = '0;
    if ((act_r == ACT_ALLOC) || ((act_r == ACT_REALLOC) && ptr_null)) begin
      do_alloc = fit;
      status   = fit ? STS_OK : STS_NO_SPACE;
      res      = fit ? new_addr : '0;
      if (fit && flags_r[ZERO_FLAG_BIT]) begin
        kind = MOVE_ZERO;
        dst  = new_addr;
        len  = asize_w[LEN_W-1:0];
      end
    end else if ((act_r == ACT_FREE) || ((act_r == ACT_REALLOC) && size_zero)) begin
      if (ptr_null) begin
        status = STS_NULL_PTR;
        res    = ADDR_W'(1);
      end else begin
        status     = hdr_sts;
        do_release = (hdr_sts == STS_OK);
        res        = (hdr_sts == STS_OK) ? ADDR_W'(1) : '0;
      end
      if (act_r == ACT_REALLOC) begin
        res = '0;
      end
    end else if (act_r == ACT_REALLOC) begin
      if (hdr_sts == STS_OK) begin
        status = fit ? STS_OK : STS_NO_SPACE;
        if (fit) begin
          do_alloc   = 1'b1;
          do_release = 1'b1;
          res        = new_addr;
          kind       = MOVE_COPY;
          src        = ptr_r;
          dst        = new_addr;
          len        = copy_len[LEN_W-1:0];
        end
      end else begin
        status = hdr_sts;
      end
    end else begin
      if (ptr_null) begin
        status = STS_NULL_PTR;
      end else begin
        status = hdr_sts;
        res    = (hdr_sts == STS_OK) ? ADDR_W'(t_size) : '1;
      end
    end
  end

  assign nfo_nxt       = do_alloc ? (nfo_r + total[OFFW-1:0]) : nfo_r;
  assign alloc_sum_nxt = do_alloc ? (alloc_sum_r + aligned[ADDR_W-1:0]) : alloc_sum_r;
  assign freed_sum_nxt = do_release ? (freed_sum_r + ADDR_W'(t_size)) : freed_sum_r;

  // Tag write port: clearing pass, new header, or freed old header.
  always_comb begin
    we    = 1'b0;
    waddr = rd_addr;
    wdata = {TAG_FREED, t_size};
    if (cmd.clear) begin
      we    = 1'b1;
      waddr = clr_cnt_r;
      wdata = {TAG_NONE, {OFFW{1'b0}}};
    end else if (cmd.commit && do_alloc) begin
      we    = 1'b1;
      waddr = nfo_idx;
      wdata = {TAG_LIVE, asize};
    end else if ((cmd.commit && do_release) || cmd.wr_old) begin
      we    = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (we) begin
      tag_mem[waddr] <= wdata;
    end
    rd_data_r <= tag_mem[rd_addr];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      clr_cnt_r   <= '0;
      base_r      <= '0;
      nfo_r       <= '0;
      alloc_sum_r <= '0;
      freed_sum_r <= '0;
      out_valid_r <= 1'b0;
    end else begin
      if (cmd.clear) begin
        clr_cnt_r <= clr_cnt_r + IDXW'(1);
      end
      if (cfg_we) begin
        base_r <= cfg_data;
      end
      if (cmd.commit) begin
        nfo_r       <= nfo_nxt;
        alloc_sum_r <= alloc_sum_nxt;
        freed_sum_r <= freed_sum_nxt;
        out_valid_r <= 1'b1;
      end else if (out_ch.ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      act_r   <= in_action;
      flags_r <= in_request_flags;
      ptr_r   <= in_block_pointer;
      size_r  <= in_request_size;
    end
    if (cmd.commit) begin
      res_r    <= res;
      status_r <= status;
      kind_r   <= kind;
      src_r    <= src;
      dst_r    <= dst;
      len_r    <= len;
    end
  end

  assign sts.clear_last  = (clr_cnt_r == IDXW'(DEPTH - 1));
  assign sts.out_free    = !out_valid_r || out_ch.ready;
  assign sts.need_second = do_alloc && do_release;

  assign out_ch.valid                 = out_valid_r;
  assign out_ch.result_value          = res_r;
  assign out_ch.status                = status_r;
  assign out_ch.move_kind             = kind_r;
  assign out_ch.move_source           = src_r;
  assign out_ch.move_destination      = dst_r;
  assign out_ch.move_length           = len_r;
  assign out_ch.bytes_allocated_total = alloc_sum_r;
  assign out_ch.bytes_freed_total     = freed_sum_r;

endmodule

`default_nettype wire

// ===== rtl/bump_heap_allocator.sv =====
`timescale 1ns / 1ps
`default_nettype none
// Each request is captured, its header tag is read, and its result is then registered as it
// executes; an earlier result that still waits for the sink holds that execute step back.
// A new request is taken only once the previous one has executed; a reallocate that succeeds
// adds a step, because the new header and the freed old header share the single tag write port.
// Reset: synchronous, active low; the tag store is then cleared one entry per cycle, all
// (HEAP_BYTES+3)/4 entries (16384 by default), during which no request is accepted.

module bump_heap_allocator
  import bha_pkg::*;
#(
  parameter int HEAP_BYTES   = BHA_HEAP_BYTES,
  parameter int HEADER_BYTES = BHA_HEADER_BYTES
) (
  input  wire logic  clk,
  input  wire logic  rst_n,
  bha_cfg_if.sink    cfg_ch,
  bha_in_if.sink     in_ch,
  bha_out_if.source  out_ch
);

  // The controller sequences each request: capture, tag read, execute, and for a
  // successful reallocate a further state to mark the old header freed. The
  // datapath holds the tag memory, the bump pointer, the running totals and the
  // result register, so a finished result can wait for the sink while the next
  // request is taken in.
  bha_cmd_t cmd;
  bha_sts_t sts;
  logic     in_ready;

  // The base address register takes a write in any cycle. It must only be written
  // while no request is in flight; the block itself does not enforce this.
  assign cfg_ch.ready = 1'b1;
  assign in_ch.ready  = in_ready;

  bha_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_ch.valid),
    .in_ready (in_ready),
    .sts      (sts),
    .cmd      (cmd)
  );

  bha_datapath #(
    .HEAP_BYTES   (HEAP_BYTES),
    .HEADER_BYTES (HEADER_BYTES)
  ) u_datapath (
    .clk              (clk),
    .rst_n            (rst_n),
    .cfg_we           (cfg_ch.valid),
    .cfg_data         (cfg_ch.data),
    .in_action        (in_ch.action),
    .in_request_flags (in_ch.request_flags),
    .in_block_pointer (in_ch.block_pointer),
    .in_request_size  (in_ch.request_size),
    .cmd              (cmd),
    .sts              (sts),
    .out_ch           (out_ch)
  );

endmodule

`default_nettype wire

// ===== sim/bump_heap_allocator_tb.sv =====
`timescale 1ns / 1ps

// Self-checking bench for the bump heap allocator. Each request transaction that the block
// accepts is run through a behavioral model of the allocator kept in this module. The model
// holds its own tag store, bump offset and byte totals. Its outcome is queued and then
// compared field by field with the result transaction that comes back.
module bump_heap_allocator_tb;
  import bha_pkg::*;

  localparam int HEAP_BYTES   = BHA_HEAP_BYTES;
  localparam int HEADER_BYTES = BHA_HEADER_BYTES;
  localparam int TAG_DEPTH    = (HEAP_BYTES + 3) / 4;

  // The clearing pass after reset takes one cycle per tag entry, so the watchdog allows for
  // it several times over before it declares the block hung.
  localparam int STALL_LIMIT = 4 * TAG_DEPTH + 10000;

  localparam logic [ADDR_W-1:0] ZERO_FILL = ADDR_W'(1) << ZERO_FLAG_BIT;
  localparam logic [ADDR_W-1:0] ALL_ONES  = '1;
  localparam logic [ADDR_W-1:0] NO_FLAGS  = '0;

  typedef struct packed {
    logic [ACT_W-1:0]  action;
    logic [ADDR_W-1:0] request_flags;
    logic [ADDR_W-1:0] block_pointer;
    logic [ADDR_W-1:0] request_size;
  } heap_request_t;

  typedef struct packed {
    logic [ADDR_W-1:0] result_value;
    logic [STS_W-1:0]  status;
    logic [KIND_W-1:0] move_kind;
    logic [ADDR_W-1:0] move_source;
    logic [ADDR_W-1:0] move_destination;
    logic [LEN_W-1:0]  move_length;
    logic [ADDR_W-1:0] bytes_allocated_total;
    logic [ADDR_W-1:0] bytes_freed_total;
  } heap_outcome_t;

  // A hand-written answer for a directed request. When fixed is set, result_value and status
  // come from here instead of the model.
  typedef struct packed {
    bit                fixed;
    logic [ADDR_W-1:0] result_value;
    logic [STS_W-1:0]  status;
  } known_answer_t;

  typedef struct packed {
    heap_request_t req;
    known_answer_t answer;
  } directed_row_t;

  localparam known_answer_t MODEL_ONLY = '{1'b0, '0, STS_OK};

  // Directed opening sequence, run right after reset with the heap base at zero. Blocks are
  // placed at 12 (size 0), 24 (size 8) and 44 (size 0). The realloc of 12 then places a block
  // of 104 bytes at 56, which leaves the bump offset at 160.
  localparam int DIRECTED_COUNT = 26;
  localparam directed_row_t DIRECTED_ROWS [DIRECTED_COUNT] = '{
    // Null pointer handling: size query, free, and realloc that turns into an allocation.
    '{'{ACT_SIZE,    NO_FLAGS, 32'd0, 32'd0}, '{1'b1, 32'd0, STS_NULL_PTR}},
    '{'{ACT_FREE,    NO_FLAGS, 32'd0, 32'd0}, '{1'b1, 32'd1, STS_NULL_PTR}},
    '{'{ACT_REALLOC, NO_FLAGS, 32'd0, 32'd0}, '{1'b1, 32'd12, STS_OK}},
    // The largest size must not wrap when it is rounded up.
    '{'{ACT_ALLOC,   ALL_ONES, 32'd0, ALL_ONES}, '{1'b1, 32'd0, STS_NO_SPACE}},
    // Zero fill of a rounded block and of an empty one.
    '{'{ACT_ALLOC,   ZERO_FILL, 32'd0, 32'd1}, '{1'b1, 32'd24, STS_OK}},
    '{'{ACT_ALLOC,   ZERO_FILL, 32'd0, 32'd0}, '{1'b1, 32'd44, STS_OK}},
    '{'{ACT_SIZE,    NO_FLAGS, 32'd24, 32'd0}, '{1'b1, 32'd8, STS_OK}},
    '{'{ACT_SIZE,    NO_FLAGS, 32'd12, 32'd0}, '{1'b1, 32'd0, STS_OK}},
    // Free, then double free, and a size query on the freed block.
    '{'{ACT_FREE,    NO_FLAGS, 32'd24, 32'd0}, '{1'b1, 32'd1, STS_OK}},
    '{'{ACT_FREE,    NO_FLAGS, 32'd24, 32'd0}, '{1'b1, 32'd0, STS_DOUBLE_FREE}},
    '{'{ACT_SIZE,    NO_FLAGS, 32'd24, 32'd0}, '{1'b1, ALL_ONES, STS_DOUBLE_FREE}},
    // A header off the word grid, and a word that holds no header.
    '{'{ACT_FREE,    NO_FLAGS, 32'd25, 32'd0}, '{1'b1, 32'd0, STS_BAD_HEADER}},
    '{'{ACT_FREE,    NO_FLAGS, 32'd28, 32'd0}, '{1'b1, 32'd0, STS_BAD_HEADER}},
    // Both edges of the valid pointer range.
    '{'{ACT_FREE,    NO_FLAGS, 32'd11, 32'd0}, '{1'b1, 32'd0, STS_OUT_RANGE}},
    '{'{ACT_FREE,    NO_FLAGS, 32'(HEAP_BYTES), 32'd0}, '{1'b1, 32'd0, STS_OUT_RANGE}},
    '{'{ACT_SIZE,    NO_FLAGS, ALL_ONES, 32'd0}, '{1'b1, ALL_ONES, STS_OUT_RANGE}},
    '{'{ACT_REALLOC, NO_FLAGS, 32'd8, 32'd16}, '{1'b1, 32'd0, STS_OUT_RANGE}},
    '{'{ACT_REALLOC, NO_FLAGS, 32'd28, 32'd8}, '{1'b1, 32'd0, STS_BAD_HEADER}},
    // Realloc with a copy, which drops the zero-fill request.
    '{'{ACT_REALLOC, ZERO_FILL, 32'd12, 32'd100}, '{1'b1, 32'd56, STS_OK}},
    // Realloc to size zero frees the block but reports a zero result.
    '{'{ACT_REALLOC, NO_FLAGS, 32'd56, 32'd0}, '{1'b1, 32'd0, STS_OK}},
    '{'{ACT_REALLOC, NO_FLAGS, 32'd56, 32'd8}, '{1'b1, 32'd0, STS_DOUBLE_FREE}},
    // A realloc that cannot be placed keeps the old block alive.
    '{'{ACT_REALLOC, NO_FLAGS, 32'd44, ALL_ONES}, '{1'b1, 32'd0, STS_NO_SPACE}},
    // Misses the end of the region by four bytes once the size has been rounded up.
    '{'{ACT_ALLOC,   ZERO_FILL, 32'd0, 32'(HEAP_BYTES - 172)}, '{1'b1, 32'd0, STS_NO_SPACE}},
    '{'{ACT_REALLOC, ALL_ONES, 32'd44, 32'd4}, MODEL_ONLY},
    '{'{ACT_ALLOC,   ~ZERO_FILL, 32'd0, 32'd7}, MODEL_ONLY},
    '{'{ACT_SIZE,    NO_FLAGS, 32'd44, 32'd0}, '{1'b1, ALL_ONES, STS_DOUBLE_FREE}}
  };

  logic clk;
  logic rst_n;

  bha_cfg_if cfg_ch ();
  bha_in_if  in_ch ();
  bha_out_if out_ch ();

  bump_heap_allocator dut (
    .clk    (clk),
    .rst_n  (rst_n),
    .cfg_ch (cfg_ch),
    .in_ch  (in_ch),
    .out_ch (out_ch)
  );

  always #6 clk = ~clk;

  // Allocator model state. It mirrors what the block holds after reset and after each
  // accepted transaction.
  logic [ADDR_W-1:0]  heap_base;
  longint unsigned    bump_offset;
  logic [TKIND_W-1:0] tag_kind_mem [TAG_DEPTH];
  logic [ADDR_W-1:0]  tag_size_mem [TAG_DEPTH];
  logic [ADDR_W-1:0]  allocated_bytes;
  logic [ADDR_W-1:0]  released_bytes;

  heap_outcome_t      pending_outcomes [$];
  known_answer_t      directed_answers [$];
  logic [ADDR_W-1:0]  issued_blocks [$];

  int unsigned        mismatch_count;
  int unsigned        stall_cycles;
  int unsigned        in_idle_pct;
  int unsigned        out_stall_pct;

  // Looks up the header that belongs to a data pointer and returns the status that the block
  // should report for it. The tag slot is returned through slot.
  function automatic logic [STS_W-1:0] locate_header(input logic [ADDR_W-1:0] ptr,
                                                     output int unsigned slot);
    logic [ADDR_W-1:0] offset;
    logic [ADDR_W-1:0] header_pos;
    offset = ptr - heap_base;
    slot = 0;
    if (offset < ADDR_W'(HEADER_BYTES) || offset >= ADDR_W'(HEAP_BYTES)) return STS_OUT_RANGE;
    header_pos = offset - ADDR_W'(HEADER_BYTES);
    if (header_pos[1:0] != 2'b00) return STS_BAD_HEADER;
    slot = header_pos >> 2;
    if (slot >= TAG_DEPTH) return STS_BAD_HEADER;
    case (tag_kind_mem[slot])
      TAG_LIVE:  return STS_OK;
      TAG_FREED: return STS_DOUBLE_FREE;
      default:   return STS_BAD_HEADER;
    endcase
  endfunction

  // Places a new block at the bump offset. The size is rounded in 64 bits, so a huge
  // request fails rather than wrapping to a small one.
  function automatic logic [STS_W-1:0] bump_allocate(input logic [ADDR_W-1:0] size,
                                                     output logic [ADDR_W-1:0] addr,
                                                     output logic [ADDR_W-1:0] rounded);
    longint unsigned aligned;
    longint unsigned footprint;
    int unsigned     slot;
    aligned = (longint'(size) + ALIGN_MASK) & ~longint'(ALIGN_MASK);
    footprint = aligned + HEADER_BYTES;
    addr = '0;
    rounded = '0;
    if (bump_offset + footprint > HEAP_BYTES) return STS_NO_SPACE;
    slot = int'(bump_offset >> 2);
    if (slot < TAG_DEPTH) begin
      tag_kind_mem[slot] = TAG_LIVE;
      tag_size_mem[slot] = ADDR_W'(aligned);
    end
    addr = heap_base + ADDR_W'(bump_offset) + ADDR_W'(HEADER_BYTES);
    rounded = ADDR_W'(aligned);
    bump_offset += footprint;
    allocated_bytes += ADDR_W'(aligned);
    return STS_OK;
  endfunction

  function automatic void retire_block(input int unsigned slot);
    tag_kind_mem[slot] = TAG_FREED;
    released_bytes += tag_size_mem[slot];
  endfunction

  // Works out the result of one request and moves the model state on.
  function automatic heap_outcome_t allocator_outcome(input heap_request_t req);
    heap_outcome_t     o;
    int unsigned       slot;
    logic [ADDR_W-1:0] addr;
    logic [ADDR_W-1:0] rounded;
    logic [ADDR_W-1:0] prior_size;
    o = '0;
    if (req.action == ACT_ALLOC || (req.action == ACT_REALLOC && req.block_pointer == '0)) begin
      o.status = bump_allocate(req.request_size, addr, rounded);
      o.result_value = addr;
      if (o.status == STS_OK && req.request_flags[ZERO_FLAG_BIT]) begin
        o.move_kind = MOVE_ZERO;
        o.move_destination = addr;
        o.move_length = LEN_W'(rounded);
      end
    end else if (req.action == ACT_FREE ||
                 (req.action == ACT_REALLOC && req.request_size == '0)) begin
      if (req.block_pointer == '0) begin
        o.status = STS_NULL_PTR;
        o.result_value = 32'd1;
      end else begin
        o.status = locate_header(req.block_pointer, slot);
        if (o.status == STS_OK) begin
          retire_block(slot);
          o.result_value = 32'd1;
        end
      end
      // A realloc that frees reports a zero pointer whatever the free did.
      if (req.action == ACT_REALLOC) o.result_value = '0;
    end else if (req.action == ACT_REALLOC) begin
      o.status = locate_header(req.block_pointer, slot);
      if (o.status == STS_OK) begin
        prior_size = tag_size_mem[slot];
        o.status = bump_allocate(req.request_size, addr, rounded);
        if (o.status == STS_OK) begin
          o.result_value = addr;
          o.move_kind = MOVE_COPY;
          o.move_source = req.block_pointer;
          o.move_destination = addr;
          o.move_length = LEN_W'((req.request_size < prior_size) ? req.request_size : prior_size);
          retire_block(slot);
        end
      end
    end else begin
      if (req.block_pointer == '0) begin
        o.status = STS_NULL_PTR;
      end else begin
        o.status = locate_header(req.block_pointer, slot);
        o.result_value = (o.status == STS_OK) ? tag_size_mem[slot] : ALL_ONES;
      end
    end
    o.bytes_allocated_total = allocated_bytes;
    o.bytes_freed_total = released_bytes;
    return o;
  endfunction

  function automatic void check_field(input string field, input logic [ADDR_W-1:0] want,
                                      input logic [ADDR_W-1:0] got);
    if (got !== want) begin
      $error("%s: expected 0x%08h, got 0x%08h", field, want, got);
      mismatch_count++;
    end
  endfunction

  // Receiver: stalls at random at the rate that the current phase sets.
  always @(negedge clk) begin
    out_ch.ready <= ($urandom_range(0, 99) >= out_stall_pct);
  end

  // Monitor. Everything is sampled at the rising edge, with the inputs steady since the
  // falling edge. A configuration write updates the model base. A result transaction is
  // checked before the request transaction of the same edge is modeled, since the result
  // always belongs to an older request.
  always @(posedge clk) begin : monitor
    heap_request_t req;
    heap_outcome_t want;
    known_answer_t answer;
    bit            moved;
    moved = 1'b0;
    if (rst_n) begin
      if (cfg_ch.valid && cfg_ch.ready) begin
        heap_base = cfg_ch.data;
        moved = 1'b1;
      end
      if (out_ch.valid && out_ch.ready) begin
        moved = 1'b1;
        if (pending_outcomes.size() == 0) begin
          $error("result transaction arrived with no request outstanding");
          mismatch_count++;
        end else begin
          want = pending_outcomes.pop_front();
          check_field("result_value", want.result_value, out_ch.result_value);
          check_field("status", ADDR_W'(want.status), ADDR_W'(out_ch.status));
          check_field("move_kind", ADDR_W'(want.move_kind), ADDR_W'(out_ch.move_kind));
          check_field("move_source", want.move_source, out_ch.move_source);
          check_field("move_destination", want.move_destination, out_ch.move_destination);
          check_field("move_length", ADDR_W'(want.move_length), ADDR_W'(out_ch.move_length));
          check_field("bytes_allocated_total", want.bytes_allocated_total,
                      out_ch.bytes_allocated_total);
          check_field("bytes_freed_total", want.bytes_freed_total, out_ch.bytes_freed_total);
        end
      end
      if (in_ch.valid && in_ch.ready) begin
        moved = 1'b1;
        req = '{in_ch.action, in_ch.request_flags, in_ch.block_pointer, in_ch.request_size};
        want = allocator_outcome(req);
        answer = directed_answers.pop_front();
        if (answer.fixed) begin
          want.result_value = answer.result_value;
          want.status = answer.status;
        end
        pending_outcomes.push_back(want);
        // New blocks feed the pointer pool of the random requests. Only recent ones are
        // kept, as they are the most likely to still be live.
        if (want.status == STS_OK && want.result_value != '0 &&
            (req.action == ACT_ALLOC || req.action == ACT_REALLOC)) begin
          issued_blocks.push_back(want.result_value);
          if (issued_blocks.size() > 48) void'(issued_blocks.pop_front());
        end
      end
    end
    // Watchdog: it counts cycles in which no channel moves a transaction.
    stall_cycles = moved ? 0 : stall_cycles + 1;
    if (stall_cycles >= STALL_LIMIT) begin
      $display("*** FAILED ***");
      $finish;
    end
  end

  // Every driving task is entered at a falling edge and returns at one.
  task automatic send_request(input heap_request_t req, input known_answer_t answer);
    while ($urandom_range(0, 99) < in_idle_pct) begin
      in_ch.valid <= 1'b0;
      @(negedge clk);
    end
    directed_answers.push_back(answer);
    in_ch.valid <= 1'b1;
    in_ch.action <= req.action;
    in_ch.request_flags <= req.request_flags;
    in_ch.block_pointer <= req.block_pointer;
    in_ch.request_size <= req.request_size;
    @(posedge clk);
    while (!in_ch.ready) @(posedge clk);
    @(negedge clk);
  endtask

  task automatic write_heap_base(input logic [ADDR_W-1:0] base);
    cfg_ch.valid <= 1'b1;
    cfg_ch.data <= base;
    @(posedge clk);
    while (!cfg_ch.ready) @(posedge clk);
    @(negedge clk);
    cfg_ch.valid <= 1'b0;
  endtask

  // Holds the request channel quiet until every outstanding result has come back.
  task automatic wait_for_results();
    in_ch.valid <= 1'b0;
    while (pending_outcomes.size() != 0) @(negedge clk);
    repeat (4) @(negedge clk);
  endtask

  // Sizes are mostly small so that the region lasts the whole run. A few are large, and a
  // few are arbitrary 32-bit values that will seldom fit.
  function automatic logic [ADDR_W-1:0] random_size();
    int unsigned roll;
    roll = $urandom_range(0, 99);
    if (roll < 8) return '0;
    if (roll < 74) return $urandom_range(1, 48);
    if (roll < 94) return $urandom_range(49, 256);
    if (roll < 97) return $urandom_range(257, 2048);
    return $urandom();
  endfunction

  // Mostly pointers that the block handed out. The rest are null, pointers just past a real
  // one, arbitrary spots in and around the region, and arbitrary 32-bit values.
  function automatic logic [ADDR_W-1:0] random_pointer();
    int unsigned roll;
    logic [ADDR_W-1:0] known;
    roll = $urandom_range(0, 99);
    known = (issued_blocks.size() != 0) ?
            issued_blocks[$urandom_range(0, issued_blocks.size() - 1)] : heap_base + 12;
    if (roll < 58) return known;
    if (roll < 66) return '0;
    if (roll < 76) return known + $urandom_range(1, 8);
    if (roll < 90) return heap_base + $urandom_range(0, HEAP_BYTES + 16);
    return $urandom();
  endfunction

  task automatic send_random_requests(input int unsigned count);
    heap_request_t req;
    int unsigned   roll;
    repeat (count) begin
      roll = $urandom_range(0, 99);
      if (roll < 35) req.action = ACT_ALLOC;
      else if (roll < 55) req.action = ACT_FREE;
      else if (roll < 80) req.action = ACT_REALLOC;
      else req.action = ACT_SIZE;
      req.request_flags = $urandom();
      req.block_pointer = random_pointer();
      req.request_size = random_size();
      send_request(req, MODEL_ONLY);
    end
  endtask

  initial begin : stimulus
    heap_request_t   req;
    longint unsigned room;
    clk = 1'b0;
    rst_n = 1'b0;
    in_ch.valid = 1'b0;
    in_ch.action = ACT_ALLOC;
    in_ch.request_flags = '0;
    in_ch.block_pointer = '0;
    in_ch.request_size = '0;
    cfg_ch.valid = 1'b0;
    cfg_ch.data = '0;
    out_ch.ready = 1'b0;
    heap_base = '0;
    bump_offset = 0;
    allocated_bytes = '0;
    released_bytes = '0;
    mismatch_count = 0;
    stall_cycles = 0;
    for (int i = 0; i < TAG_DEPTH; i++) begin
      tag_kind_mem[i] = TAG_NONE;
      tag_size_mem[i] = '0;
    end

    // Phase one: the sender idles a quarter of the time and the receiver stalls a little
    // under half of it.
    in_idle_pct = 25;
    out_stall_pct = 46;
    repeat (6) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    // The block accepts nothing until its tag store has been cleared.
    write_heap_base('0);
    for (int i = 0; i < DIRECTED_COUNT; i++) begin
      send_request(DIRECTED_ROWS[i].req, DIRECTED_ROWS[i].answer);
    end
    send_random_requests(270);
    wait_for_results();

    // Phase two: the idle rates swap, and the heap base moves to the top of the address
    // space so that block addresses wrap around zero.
    write_heap_base(ALL_ONES);
    in_idle_pct = 46;
    out_stall_pct = 25;
    send_random_requests(280);
    wait_for_results();

    // Phase three: no idling at all, with an arbitrary base.
    write_heap_base($urandom());
    in_idle_pct = 0;
    out_stall_pct = 0;
    send_random_requests(250);
    wait_for_results();

    // Fill the rest of the region as far as the rounding allows, zero-filled, so that even an empty
    // block no longer fits. Then run a little more traffic against the full heap.
    if (bump_offset + HEADER_BYTES <= HEAP_BYTES) begin
      room = HEAP_BYTES - HEADER_BYTES - bump_offset;
      req = '{ACT_ALLOC, ZERO_FILL, '0, ADDR_W'(room & ~longint'(ALIGN_MASK))};
      send_request(req, MODEL_ONLY);
    end
    req = '{ACT_ALLOC, NO_FLAGS, '0, '0};
    send_request(req, MODEL_ONLY);
    send_random_requests(40);
    wait_for_results();

    repeat (8) @(negedge clk);
    if (mismatch_count == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end

endmodule

// ===== sim.f =====
rtl/bha_pkg.sv
rtl/bha_in_if.sv
rtl/bha_out_if.sv
rtl/bha_cfg_if.sv
rtl/bha_ctrl.sv
rtl/bha_datapath.sv
rtl/bump_heap_allocator.sv
sim/bump_heap_allocator_tb.sv
